/* rtl/cepi_pkg.sv */
// Shared types and constants for the cosine ease pose interpolator.
`default_nettype none

package cepi_pkg;

    // Axis count and field widths
    localparam int NAXES  = 3;
    localparam int POS_W  = 10;
    localparam int STEP_W = 7;
    localparam int EASE_W = 17;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd1;

    // Window reset values
    localparam logic [POS_W-1:0] FLOOR_RST   = 10'd0;
    localparam logic [POS_W-1:0] CEILING_RST = 10'd1023;

    typedef logic [POS_W-1:0] pos_t;
    typedef pos_t [NAXES-1:0] pos_vec_t;

    // Control tag that travels beside the lane pipeline
    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
        logic              last;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/cepi_lane.sv */
// One axis lane: ease product, then round half up and clamp to the window.
`default_nettype none

module cepi_lane (
    input  wire logic                         clk,
    input  wire logic                         advance,
    input  wire logic [cepi_pkg::EASE_W-1:0]  ease,
    input  wire cepi_pkg::pos_t               start_pos,
    input  wire cepi_pkg::pos_t               goal_pos,
    input  wire cepi_pkg::pos_t               floor_pos,
    input  wire cepi_pkg::pos_t               ceiling_pos,
    output cepi_pkg::pos_t                    setpoint
);
    import cepi_pkg::*;

    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = DIFF_W + EASE_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [EASE_W:0]   ease_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc;
    pos_t                     raw;
    pos_t                     res_next;
    pos_t                     res_reg;

    // Signed distance times ease factor
    assign diff      = $signed({1'b0, goal_pos}) - $signed({1'b0, start_pos});
    assign ease_s    = $signed({1'b0, ease});
    assign prod_next = PROD_W'(diff) * PROD_W'(ease_s);

    // Add the start in Q16 with the half-count round bias
    assign acc = $signed({{(PROD_W-POS_W-16){1'b0}}, start_pos, 16'h8000}) + prod_reg;
    assign raw = acc[POS_W+15:16];

    // Clamp: floor is tested first
    always_comb
    begin
        if (raw < floor_pos)
            res_next = floor_pos;
        else if (raw > ceiling_pos)
            res_next = ceiling_pos;
        else
            res_next = raw;
    end

    // Advance both lane stages with the pipeline
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            res_reg  <= res_next;
        end
    end

    assign setpoint = res_reg;

endmodule

`default_nettype wire

/* rtl/cepi_merge.sv */
// Merge stage: joins the lane results and the step tag into the output beat register.
`default_nettype none

module cepi_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cepi_pkg::tag_t              tag,
    input  wire cepi_pkg::pos_vec_t          lane_sp,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output cepi_pkg::pos_vec_t               out_sp,
    output logic [cepi_pkg::STEP_W-1:0]      out_step,
    output logic                             out_last,
    output logic                             advance
);
    import cepi_pkg::*;

    logic              valid_reg;
    pos_vec_t          sp_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_reg;

    // Move the whole pipeline when the output slot is free or drained
    assign advance = !valid_reg || out_ready;

    // Hold valid state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tag.valid;
    end

    // Capture the beat payload
    always_ff @(posedge clk)
    begin
        if (advance && tag.valid)
        begin
            sp_reg   <= lane_sp;
            step_reg <= tag.step;
            last_reg <= tag.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_sp    = sp_reg;
    assign out_step  = step_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

/* rtl/cosine_ease_pose_interpolator.sv */
// Top level: move sequencer, ease table, three axis lanes and the merge stage.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid / in_ready              | start_axis0..2, goal_axis0..2
//  out     | out_valid / out_ready            | setpoint_axis0..2, step_number, final_step
//  cfg     | cfg_valid / cfg_ready            | cfg_index, cfg_data (floor, ceiling)
//
//  One move yields STEPS beats, one per cycle while out_ready holds high.
//  A move occupies the block until its final beat is delivered: the step counter issues
//  one step a cycle, unless stalled, into a four-register path (ease table, lane product,
//  lane clamp, output). in_ready is high only when no move is in flight; the next move is
//  taken the cycle after the final beat is delivered. Low out_ready stalls the whole path.
//  Reset clears the counter, the busy flag and the valid bits, and loads the window reset values.
`default_nettype none

module cosine_ease_pose_interpolator #(
    parameter int STEPS = 60
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cepi_pkg::pos_t                start_axis0,
    input  wire cepi_pkg::pos_t                start_axis1,
    input  wire cepi_pkg::pos_t                start_axis2,
    input  wire cepi_pkg::pos_t                goal_axis0,
    input  wire cepi_pkg::pos_t                goal_axis1,
    input  wire cepi_pkg::pos_t                goal_axis2,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cepi_pkg::pos_t                     setpoint_axis0,
    output cepi_pkg::pos_t                     setpoint_axis1,
    output cepi_pkg::pos_t                     setpoint_axis2,
    output logic [cepi_pkg::STEP_W-1:0]        step_number,
    output logic                               final_step,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cepi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire cepi_pkg::pos_t                cfg_data
);
    import cepi_pkg::*;

    localparam int IDX_W = $clog2(STEPS + 1);

    // Q30 fixed-point constants for the cosine series
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] C_8     = Q30_ONE / 64'd40320;
    localparam logic [63:0] C_10    = Q30_ONE / 64'd3628800;
    localparam logic [63:0] C_6     = Q30_ONE / 64'd720;
    localparam logic [63:0] C_4     = Q30_ONE / 64'd24;
    localparam logic [63:0] C_2     = Q30_ONE / 64'd2;
    localparam logic [63:0] HALF_N  = 64'(STEPS / 2);
    localparam logic [63:0] EASE_ONE = 64'd65536;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS);

    // Ease for the first half of the move, Q0.16
    function automatic logic [EASE_W-1:0] ease_half(input logic [STEP_W-1:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] e;
        x  = (PI_Q30 * 64'(r) + HALF_N) / 64'(STEPS);
        x2 = (x * x) >> 30;
        p  = C_8 - ((x2 * C_10) >> 30);
        p  = C_6 - ((x2 * p) >> 30);
        p  = C_4 - ((x2 * p) >> 30);
        p  = C_2 - ((x2 * p) >> 30);
        e  = (((x2 * p) >> 30) + 64'd16384) >> 15;
        return e[EASE_W-1:0];
    endfunction

    // Ease over the whole move, mirrored past the midpoint
    function automatic logic [EASE_W-1:0] ease_at(input logic [STEP_W-1:0] s);
        logic [63:0] e;
        if (2 * 64'(s) > 64'(STEPS))
            e = EASE_ONE - 64'(ease_half(STEP_W'(STEPS) - s));
        else
            e = 64'(ease_half(s));
        return e[EASE_W-1:0];
    endfunction

    // Constant ease table, one entry per step
    logic [EASE_W-1:0] ease_rom [STEPS+1];

    for (genvar g = 0; g <= STEPS; g++)
    begin : g_rom
        localparam logic [EASE_W-1:0] EV = ease_at(STEP_W'(g));
        assign ease_rom[g] = EV;
    end

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    pos_t              floor_reg;
    pos_t              ceiling_reg;
    pos_vec_t          start_reg;
    pos_vec_t          goal_reg;
    logic [EASE_W-1:0] ease_reg;
    tag_t              s1_tag_reg;
    tag_t              s2_tag_reg;
    tag_t              s3_tag_reg;
    tag_t              s1_tag_next;
    logic              advance;
    logic              in_fire;
    logic              out_fire;
    logic              issue;
    pos_vec_t          lane_sp;
    pos_vec_t          out_sp;

    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign issue     = advance && (step_reg != '0);

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RST;
            ceiling_reg <= CEILING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FLOOR:   floor_reg   <= cfg_data;
                REG_CEILING: ceiling_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Latch the move request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            start_reg <= '{start_axis2, start_axis1, start_axis0};
            goal_reg  <= '{goal_axis2, goal_axis1, goal_axis0};
        end
    end

    // Busy flag and step counter
    always_comb
    begin
        busy_next = busy_reg;
        if (in_fire)
            busy_next = 1'b1;
        else if (out_fire && final_step)
            busy_next = 1'b0;

        step_next = step_reg;
        if (in_fire)
            step_next = STEP_W'(1);
        else if (issue)
            step_next = (step_reg == LAST_STEP) ? '0 : step_reg + STEP_W'(1);

        s1_tag_next.valid = issue;
        s1_tag_next.step  = step_reg;
        s1_tag_next.last  = (step_reg == LAST_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (advance)
            begin
                s1_tag_reg <= s1_tag_next;
                s2_tag_reg <= s1_tag_reg;
                s3_tag_reg <= s2_tag_reg;
            end
        end
    end

    // Look up the ease factor for the issued step
    always_ff @(posedge clk)
    begin
        if (advance)
            ease_reg <= ease_rom[step_reg[IDX_W-1:0]];
    end

    // Axis lanes
    for (genvar a = 0; a < NAXES; a++)
    begin : g_lane
        cepi_lane u_lane (
            .clk         (clk),
            .advance     (advance),
            .ease        (ease_reg),
            .start_pos   (start_reg[a]),
            .goal_pos    (goal_reg[a]),
            .floor_pos   (floor_reg),
            .ceiling_pos (ceiling_reg),
            .setpoint    (lane_sp[a])
        );
    end

    cepi_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (s3_tag_reg),
        .lane_sp   (lane_sp),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_sp    (out_sp),
        .out_step  (step_number),
        .out_last  (final_step),
        .advance   (advance)
    );

    assign setpoint_axis0 = out_sp[0];
    assign setpoint_axis1 = out_sp[1];
    assign setpoint_axis2 = out_sp[2];

    // The final beat carries the last step number
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_step) |-> (step_number == LAST_STEP))
        else $error("final beat carries wrong step number");

    // Beats of one move follow without gaps and count up by one
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !final_step) |=>
        (out_valid && (step_number == $past(step_number) + STEP_W'(1))))
        else $error("gap or skipped step inside a move");

    // No result without a move in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_reg)
        else $error("result beat while idle");

    // A new move starts with an empty pipeline
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!out_valid && !s1_tag_reg.valid && !s2_tag_reg.valid
                     && !s3_tag_reg.valid && (step_reg == '0)))
        else $error("move accepted while previous move in flight");

endmodule

`default_nettype wire

/* bench/tb_cosine_ease_pose_interpolator.sv */
// Self-checking testbench for the three-axis cosine ease pose interpolator.
module tb_cosine_ease_pose_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import cepi_pkg::*;

    localparam int STEPS = 60;

    // Window register indexes past the end of the map; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    // Fixed-point constants of the ease curve
    localparam bit [63:0] Q30_UNIT  = 64'd1073741824;
    localparam bit [63:0] PI_Q30    = 64'd3373259426;
    localparam bit [63:0] EASE_UNIT = 64'd65536;

    typedef struct packed {
        pos_vec_t          sp;
        logic [STEP_W-1:0] step;
        logic              fin;
    } setpoint_beat_t;

    typedef enum logic {ROW_MOVE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        pos_t                  reg_val;
        pos_vec_t              start;
        pos_vec_t              goal;
        bit                    typed;
        pos_vec_t              typed_sp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pos_t                 start_axis0, start_axis1, start_axis2;
    pos_t                 goal_axis0, goal_axis1, goal_axis2;
    logic                 out_valid;
    logic                 out_ready;
    pos_t                 setpoint_axis0, setpoint_axis1, setpoint_axis2;
    logic [STEP_W-1:0]    step_number;
    logic                 final_step;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    pos_t                 cfg_data;

    // Shadow copy of the window registers
    pos_t window_floor   = FLOOR_RST;
    pos_t window_ceiling = CEILING_RST;

    setpoint_beat_t setpoints_due[$];
    setpoint_beat_t due_beat;
    setpoint_beat_t got_beat;
    stim_row_t      dir_rows[$];
    int             mismatches = 0;
    bit             sender_gaps_on = 1'b1;
    int             ready_hold = 0;
    logic           ready_level = 1'b1;

    cosine_ease_pose_interpolator #(
        .STEPS(STEPS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_axis0   (start_axis0),
        .start_axis1   (start_axis1),
        .start_axis2   (start_axis2),
        .goal_axis0    (goal_axis0),
        .goal_axis1    (goal_axis1),
        .goal_axis2    (goal_axis2),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .setpoint_axis0(setpoint_axis0),
        .setpoint_axis1(setpoint_axis1),
        .setpoint_axis2(setpoint_axis2),
        .step_number   (step_number),
        .final_step    (final_step),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Ease factor for the first half of the move, Q0.16, Taylor series of 1 - cos
    function automatic bit [63:0] ease_first_half(bit [63:0] r);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] p;
        x  = (PI_Q30 * r + STEPS / 2) / STEPS;
        x2 = (x * x) >> 30;
        p  = Q30_UNIT / 40320 - ((x2 * (Q30_UNIT / 3628800)) >> 30);
        p  = Q30_UNIT / 720 - ((x2 * p) >> 30);
        p  = Q30_UNIT / 24 - ((x2 * p) >> 30);
        p  = Q30_UNIT / 2 - ((x2 * p) >> 30);
        return (((x2 * p) >> 30) + 64'd16384) >> 15;
    endfunction

    // Mirror the second half so the last step lands on exactly 1.0
    function automatic bit [63:0] ease_q16(int s);
        if (2 * s > STEPS)
            return EASE_UNIT - ease_first_half(64'(STEPS - s));
        return ease_first_half(64'(s));
    endfunction

    // Blend one axis, round half up, clamp floor first then ceiling
    function automatic pos_t eased_setpoint(pos_t a, pos_t b, bit [63:0] e);
        bit [63:0] acc;
        bit [63:0] v;
        acc = 64'(a) * EASE_UNIT + 64'd32768;
        if (b >= a)
            acc = acc + 64'(b - a) * e;
        else
            acc = acc - 64'(a - b) * e;
        v = acc >> 16;
        if (v < 64'(window_floor))
            return window_floor;
        if (v > 64'(window_ceiling))
            return window_ceiling;
        return v[POS_W-1:0];
    endfunction

    function automatic pos_vec_t axes(int a0, int a1, int a2);
        pos_vec_t v;
        v[0] = pos_t'(a0);
        v[1] = pos_t'(a1);
        v[2] = pos_t'(a2);
        return v;
    endfunction

    function automatic stim_row_t move_row(pos_vec_t s, pos_vec_t g);
        stim_row_t r;
        r.kind     = ROW_MOVE;
        r.reg_idx  = REG_FLOOR;
        r.reg_val  = '0;
        r.start    = s;
        r.goal     = g;
        r.typed    = 1'b0;
        r.typed_sp = '0;
        return r;
    endfunction

    // Start equals goal: every step is the held position, clamped
    function automatic stim_row_t hold_row(pos_vec_t p, pos_vec_t clamped);
        stim_row_t r;
        r          = move_row(p, p);
        r.typed    = 1'b1;
        r.typed_sp = clamped;
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx, int val);
        stim_row_t r;
        r         = move_row('0, '0);
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = pos_t'(val);
        return r;
    endfunction

    // Queue the STEPS setpoints that one accepted move must produce
    task automatic plan_move(pos_vec_t s, pos_vec_t g, bit typed, pos_vec_t typed_sp);
        setpoint_beat_t b;
        bit [63:0]      e;
        for (int st = 1; st <= STEPS; st++) begin
            e      = ease_q16(st);
            b.step = STEP_W'(st);
            b.fin  = (st == STEPS);
            for (int ax = 0; ax < NAXES; ax++)
                b.sp[ax] = typed ? typed_sp[ax] : eased_setpoint(s[ax], g[ax], e);
            setpoints_due.push_back(b);
        end
    endtask

    // Present one move; valid stays high across back-to-back beats unless a random gap is drawn
    task automatic send_move(pos_vec_t s, pos_vec_t g, bit typed, pos_vec_t typed_sp);
        int gap;
        int r;
        @(negedge clk);
        r   = $urandom_range(0, 99);
        gap = 0;
        if (sender_gaps_on) begin
            if (r >= 90)
                gap = $urandom_range(15, 60);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start_axis0 = s[0];
        start_axis1 = s[1];
        start_axis2 = s[2];
        goal_axis0  = g[0];
        goal_axis1  = g[1];
        goal_axis2  = g[2];
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        plan_move(s, g, typed, typed_sp);
    endtask

    // Write one window register once every pending setpoint has drained
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, pos_t val);
        @(negedge clk);
        in_valid = 1'b0;
        while (setpoints_due.size() != 0) @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FLOOR)
            window_floor = val;
        else if (idx == REG_CEILING)
            window_ceiling = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Pick a new window: wide, random, inverted or pinned to the extremes
    task automatic retune_window();
        int   shape;
        pos_t lo;
        pos_t hi;
        pos_t t;
        shape = $urandom_range(0, 99);
        lo    = pos_t'($urandom_range(0, 1023));
        hi    = pos_t'($urandom_range(0, 1023));
        if (shape < 40) begin
            lo = FLOOR_RST;
            hi = CEILING_RST;
        end else if (shape < 70) begin
            if (lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end else if (shape < 82) begin
            if (lo < hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end else begin
            case ($urandom_range(0, 3))
                0: begin lo = 10'd0;    hi = 10'd0;    end
                1: begin lo = 10'd1023; hi = 10'd1023; end
                2: begin lo = 10'd1023; hi = 10'd0;    end
                default: begin lo = 10'd0; hi = 10'd1023; end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
                           pos_t'($urandom_range(0, 1023)));
        if ($urandom_range(0, 1)) begin
            write_register(REG_FLOOR, lo);
            write_register(REG_CEILING, hi);
        end else begin
            write_register(REG_CEILING, hi);
            write_register(REG_FLOOR, lo);
        end
    endtask

    // Build a random move: free, held, end-to-end or a short nudge
    task automatic random_move();
        pos_vec_t s;
        pos_vec_t g;
        int       kind;
        int       v;
        kind = $urandom_range(0, 99);
        for (int ax = 0; ax < NAXES; ax++) begin
            s[ax] = pos_t'($urandom_range(0, 1023));
            g[ax] = pos_t'($urandom_range(0, 1023));
            if (kind >= 45 && kind < 55) begin
                g[ax] = s[ax];
            end else if (kind >= 55 && kind < 70) begin
                s[ax] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                g[ax] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            end else if (kind >= 70 && kind < 90) begin
                v = int'(s[ax]) + int'($urandom_range(0, 12)) - 6;
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
                g[ax] = pos_t'(v);
            end
        end
        send_move(s, g, 1'b0, '0);
    endtask

    // Randomize out_ready: mostly short runs and stalls, a few long ones
    always @(negedge clk) begin
        if (ready_hold == 0) begin
            if ($urandom_range(0, 99) < 60) begin
                ready_level = 1'b1;
                ready_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 6);
            end else begin
                ready_level = 1'b0;
                ready_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
            end
        end
        ready_hold = ready_hold - 1;
        out_ready  = ready_level;
    end

    // Compare every delivered beat with the oldest pending setpoint
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got_beat.sp[0] = setpoint_axis0;
            got_beat.sp[1] = setpoint_axis1;
            got_beat.sp[2] = setpoint_axis2;
            got_beat.step  = step_number;
            got_beat.fin   = final_step;
            if (setpoints_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected beat: sp=%0d/%0d/%0d step=%0d last=%0b",
                             got_beat.sp[0], got_beat.sp[1], got_beat.sp[2],
                             got_beat.step, got_beat.fin);
            end else begin
                due_beat = setpoints_due.pop_front();
                if (got_beat !== due_beat) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch: exp sp=%0d/%0d/%0d step=%0d last=%0b",
                                  " got sp=%0d/%0d/%0d step=%0d last=%0b"},
                                 due_beat.sp[0], due_beat.sp[1], due_beat.sp[2],
                                 due_beat.step, due_beat.fin,
                                 got_beat.sp[0], got_beat.sp[1], got_beat.sp[2],
                                 got_beat.step, got_beat.fin);
                end
            end
        end
    end

    // Hard stop for a hung handshake
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        start_axis0 = '0;
        start_axis1 = '0;
        start_axis2 = '0;
        goal_axis0  = '0;
        goal_axis1  = '0;
        goal_axis2  = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FLOOR;
        cfg_data    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: reset window, extremes, clamping, inverted window, spare indexes
        dir_rows.push_back(hold_row(axes(0, 0, 0), axes(0, 0, 0)));
        dir_rows.push_back(hold_row(axes(1023, 1023, 1023), axes(1023, 1023, 1023)));
        dir_rows.push_back(move_row(axes(0, 1023, 512), axes(1023, 0, 511)));
        dir_rows.push_back(move_row(axes(1023, 0, 341), axes(0, 1023, 682)));
        dir_rows.push_back(move_row(axes(341, 682, 1), axes(682, 341, 0)));
        dir_rows.push_back(write_row(REG_FLOOR, 100));
        dir_rows.push_back(write_row(REG_CEILING, 900));
        dir_rows.push_back(hold_row(axes(50, 500, 950), axes(100, 500, 900)));
        dir_rows.push_back(move_row(axes(0, 0, 1023), axes(1023, 512, 0)));
        dir_rows.push_back(write_row(REG_FLOOR, 900));
        dir_rows.push_back(write_row(REG_CEILING, 100));
        dir_rows.push_back(hold_row(axes(50, 500, 950), axes(900, 900, 100)));
        dir_rows.push_back(move_row(axes(0, 1023, 900), axes(1023, 0, 100)));
        dir_rows.push_back(write_row(REG_SPARE2, 555));
        dir_rows.push_back(write_row(REG_SPARE3, 1023));
        dir_rows.push_back(hold_row(axes(300, 899, 901), axes(900, 900, 100)));
        dir_rows.push_back(write_row(REG_FLOOR, 1023));
        dir_rows.push_back(write_row(REG_CEILING, 1023));
        dir_rows.push_back(hold_row(axes(0, 512, 1023), axes(1023, 1023, 1023)));
        dir_rows.push_back(move_row(axes(0, 1023, 0), axes(1023, 0, 1)));
        dir_rows.push_back(write_row(REG_FLOOR, 0));
        dir_rows.push_back(write_row(REG_CEILING, 0));
        dir_rows.push_back(hold_row(axes(0, 512, 1023), axes(0, 0, 0)));
        dir_rows.push_back(write_row(REG_CEILING, 1023));
        dir_rows.push_back(move_row(axes(0, 1, 1023), axes(1, 0, 1022)));
        dir_rows.push_back(move_row(axes(511, 512, 7), axes(512, 511, 1016)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_move(dir_rows[i].start, dir_rows[i].goal,
                          dir_rows[i].typed, dir_rows[i].typed_sp);
        end

        // Random phases, each with its own window and sender pacing
        for (int phase = 0; phase < 10; phase++) begin
            retune_window();
            sender_gaps_on = (phase % 3 != 1);
            for (int n = 0; n < 46; n++)
                random_move();
        end

        // Drain, then watch for stray beats
        @(negedge clk);
        in_valid = 1'b0;
        while (setpoints_due.size() != 0) @(posedge clk);
        repeat (STEPS + 8) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
